// ----- design/whp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// whp_pkg
// Shared types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] RESET_RATE     = 32'd16000;
  localparam logic [15:0] RESET_CHANNELS = 16'd1;
  localparam logic [15:0] RESET_BITS     = 16'd16;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_END    = 2'd1,
    KIND_BADHDR = 2'd2,
    KIND_UNSUP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_RAW_PCM_MODE      = 2'd0,
    REG_EXPECTED_RATE     = 2'd1,
    REG_EXPECTED_CHANNELS = 2'd2,
    REG_EXPECTED_BITS     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_first;
    logic       file_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] sample;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic        raw_pcm_mode;
    logic [31:0] expected_rate;
    logic [15:0] expected_channels;
    logic [15:0] expected_bits;
  } cfg_t;

  // One queue entry: an optional sample followed by an optional end status.
  typedef struct packed {
    logic        smp_valid;
    logic [15:0] smp;
    logic        end_valid;
    kind_t       end_kind;
  } cmd_t;

endpackage
`default_nettype wire

// ----- design/whp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// whp_front
// Byte parser: header check, chunk walk, fmt decode, sample pairing.
// ----------------------------------------------------------------------------
module whp_front import whp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     take,
  input  wire in_item_t item,
  output logic          push,
  output cmd_t          cmd
);

  typedef enum logic [6:0] {
    PH_RIFF  = 7'b000_0001,
    PH_CHUNK = 7'b000_0010,
    PH_FMT   = 7'b000_0100,
    PH_SKIP  = 7'b000_1000,
    PH_DATA  = 7'b001_0000,
    PH_RAW   = 7'b010_0000,
    PH_DONE  = 7'b100_0000
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [4:0]  byte_count, byte_count_next, bc;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] depth_seen, depth_seen_next;
  logic        format_seen, format_seen_next, fs;
  logic [7:0]  low_byte, low_byte_next;
  logic        half_sample, half_sample_next, hs;
  logic        term;
  logic [7:0]  b;
  logic [31:0] left_dec;
  logic [32:0] skip_sum;

  assign b        = item.file_byte;
  assign left_dec = bytes_left - 32'd1;

  always_comb begin
    // file_first restarts the parser before this byte is looked at
    ph = item.file_first ? PH_RIFF : phase;
    bc = item.file_first ? 5'd0 : byte_count;
    fs = item.file_first ? 1'b0 : format_seen;
    hs = item.file_first ? 1'b0 : half_sample;
    if (ph == PH_RIFF && bc == 5'd0 && cfg.raw_pcm_mode) begin
      ph = PH_RAW;
    end

    phase_next         = ph;
    byte_count_next    = bc;
    chunk_tag_next     = chunk_tag;
    chunk_length_next  = chunk_length;
    bytes_left_next    = bytes_left;
    format_code_next   = format_code;
    channel_count_next = channel_count;
    rate_seen_next     = rate_seen;
    depth_seen_next    = depth_seen;
    format_seen_next   = fs;
    low_byte_next      = low_byte;
    half_sample_next   = hs;
    cmd                = '0;
    cmd.end_kind       = KIND_END;
    term               = 1'b0;
    skip_sum           = '0;

    unique case (ph)
      PH_RIFF: begin
        chunk_tag_next  = {chunk_tag[23:0], b};
        byte_count_next = bc + 5'd1;
        if (byte_count_next == 5'd4 && chunk_tag_next != TAG_RIFF) begin
          term = 1'b1; cmd.end_kind = KIND_BADHDR;
        end else if (byte_count_next == 5'd12) begin
          if (chunk_tag_next != TAG_WAVE) begin
            term = 1'b1; cmd.end_kind = KIND_BADHDR;
          end else begin
            chunk_tag_next  = '0;
            byte_count_next = '0;
            phase_next      = PH_CHUNK;
          end
        end
      end
      PH_CHUNK: begin
        if (bc < 5'd4) begin
          chunk_tag_next = {chunk_tag[23:0], b};
        end else begin
          unique case (bc[1:0])
            2'd0: chunk_length_next = {24'd0, b};
            2'd1: chunk_length_next = {chunk_length[31:16], b, chunk_length[7:0]};
            2'd2: chunk_length_next = {chunk_length[31:24], b, chunk_length[15:0]};
            default: chunk_length_next = {b, chunk_length[23:0]};
          endcase
        end
        byte_count_next = bc + 5'd1;
        if (byte_count_next == 5'd8) begin
          byte_count_next = '0;
          chunk_tag_next  = '0;
          if (chunk_tag == TAG_FMT) begin
            if (chunk_length_next < 32'd16) begin
              term = 1'b1; cmd.end_kind = KIND_UNSUP;
            end else begin
              bytes_left_next = (chunk_length_next - 32'd16) +
                                {31'd0, chunk_length_next[0]};
              phase_next      = PH_FMT;
            end
          end else if (chunk_tag == TAG_DATA) begin
            if (!fs || format_code != 16'd1 ||
                channel_count != cfg.expected_channels ||
                rate_seen != cfg.expected_rate ||
                depth_seen != cfg.expected_bits) begin
              term = 1'b1; cmd.end_kind = KIND_UNSUP;
            end else begin
              bytes_left_next  = {chunk_length_next[31:1], 1'b0};
              half_sample_next = 1'b0;
              if (chunk_length_next[31:1] == 31'd0) begin
                term = 1'b1; cmd.end_kind = KIND_END;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end else begin
            // unknown chunk: skip payload plus pad byte, saturating
            skip_sum = {1'b0, chunk_length_next} + {32'd0, chunk_length_next[0]};
            bytes_left_next = skip_sum[32] ? 32'hFFFF_FFFF : skip_sum[31:0];
            phase_next = (bytes_left_next == 32'd0) ? PH_CHUNK : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        unique case (bc)
          5'd0:  format_code_next   = {8'd0, b};
          5'd1:  format_code_next   = {b, format_code[7:0]};
          5'd2:  channel_count_next = {8'd0, b};
          5'd3:  channel_count_next = {b, channel_count[7:0]};
          5'd4:  rate_seen_next     = {24'd0, b};
          5'd5:  rate_seen_next     = {rate_seen[31:16], b, rate_seen[7:0]};
          5'd6:  rate_seen_next     = {rate_seen[31:24], b, rate_seen[15:0]};
          5'd7:  rate_seen_next     = {b, rate_seen[23:0]};
          5'd14: depth_seen_next    = {8'd0, b};
          5'd15: depth_seen_next    = {b, depth_seen[7:0]};
          default: ;
        endcase
        byte_count_next = bc + 5'd1;
        if (byte_count_next == 5'd16) begin
          format_seen_next = 1'b1;
          byte_count_next  = '0;
          phase_next       = (bytes_left == 32'd0) ? PH_CHUNK : PH_SKIP;
        end
      end
      PH_SKIP: begin
        bytes_left_next = left_dec;
        if (left_dec == 32'd0) begin
          byte_count_next = '0;
          phase_next      = PH_CHUNK;
        end
      end
      PH_DATA, PH_RAW: begin
        if (hs) begin
          half_sample_next = 1'b0;
          cmd.smp_valid    = 1'b1;
          cmd.smp          = {b, low_byte};
        end else begin
          low_byte_next    = b;
          half_sample_next = 1'b1;
        end
        if (ph == PH_DATA) begin
          bytes_left_next = left_dec;
          if (left_dec == 32'd0) begin
            term = 1'b1; cmd.end_kind = KIND_END;
          end
        end
      end
      default: ;
    endcase

    if (term) begin
      phase_next    = PH_DONE;
      cmd.end_valid = 1'b1;
    end else if (item.file_last && ph != PH_DONE) begin
      // early end of file: kind depends on where the walk stands
      if (phase_next == PH_DATA || phase_next == PH_RAW) begin
        cmd.end_kind = KIND_END;
      end else if (phase_next == PH_RIFF) begin
        cmd.end_kind = KIND_BADHDR;
      end else begin
        cmd.end_kind = KIND_UNSUP;
      end
      cmd.end_valid    = 1'b1;
      phase_next       = PH_DONE;
      half_sample_next = 1'b0;
    end
  end

  assign push = take && (cmd.smp_valid || cmd.end_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RIFF;
      byte_count  <= '0;
      format_seen <= 1'b0;
      half_sample <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      format_seen <= format_seen_next;
      half_sample <= half_sample_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chunk_tag     <= chunk_tag_next;
      chunk_length  <= chunk_length_next;
      bytes_left    <= bytes_left_next;
      format_code   <= format_code_next;
      channel_count <= channel_count_next;
      rate_seen     <= rate_seen_next;
      depth_seen    <= depth_seen_next;
      low_byte      <= low_byte_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/whp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// whp_queue
// Short command queue between parser and result emitter.
// ----------------------------------------------------------------------------
module whp_queue import whp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      has_room,
  input  wire logic pop,
  output logic      has_data,
  output cmd_t      head
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  cmd_t        slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign has_room = count != (AW+1)'(QUEUE_DEPTH);
  assign has_data = count != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- design/whp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// whp_back
// Result emitter: turns queue commands into one or two output requests.
// ----------------------------------------------------------------------------
module whp_back import whp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic has_data,
  input  wire cmd_t head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic  pend;        // status still owed after a sample
  kind_t pend_kind;
  logic  slot_free;

  assign slot_free = !out_valid || out_ready;
  assign pop       = slot_free && !pend && has_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (slot_free) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (has_data) begin
        out_valid <= 1'b1;
        pend      <= head.smp_valid && head.end_valid;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend) begin
        out_data.result_kind <= pend_kind;
        out_data.sample      <= '0;
        out_data.last        <= 1'b1;
      end else if (has_data) begin
        pend_kind <= head.end_kind;
        if (head.smp_valid) begin
          out_data.result_kind <= KIND_SAMPLE;
          out_data.sample      <= head.smp;
          out_data.last        <= 1'b0;
        end else begin
          out_data.result_kind <= head.end_kind;
          out_data.sample      <= '0;
          out_data.last        <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/wav_header_parser_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wav_header_parser_core
// RIFF/WAVE PCM header parser and little-endian 16-bit sample extractor.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | request   | in_valid / in_ready   | in_item_t  (byte, first, last)
//  out     | request   | out_valid / out_ready | out_item_t (kind, sample, last)
//  cfg     | write     | cfg_we                | cfg_index, cfg_data
//
//  One file byte is taken per cycle while in_ready is high; the parser updates
//  all of its state in that cycle. Results leave one per cycle from the output
//  register while out_ready is high; a sample plus end status is two results.
//  in_ready drops only when the four-entry command queue is full.
//  Synchronous reset clears parser phase, queue and output; no clearing pass.
// ----------------------------------------------------------------------------
module wav_header_parser_core import whp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cfg_t cfg;
  logic take, push, pop, q_room, q_data;
  cmd_t cmd, head;

  // configuration registers: user writes only while block idle; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_pcm_mode      <= 1'b0;
      cfg.expected_rate     <= RESET_RATE;
      cfg.expected_channels <= RESET_CHANNELS;
      cfg.expected_bits     <= RESET_BITS;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_RAW_PCM_MODE:      cfg.raw_pcm_mode      <= cfg_data[0];
        REG_EXPECTED_RATE:     cfg.expected_rate     <= cfg_data;
        REG_EXPECTED_CHANNELS: cfg.expected_channels <= cfg_data[15:0];
        REG_EXPECTED_BITS:     cfg.expected_bits     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front accepts a byte whenever the queue can hold its command
  assign in_ready = q_room;
  assign take     = in_valid && in_ready;

  whp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .item (in_data),
    .push (push),
    .cmd  (cmd)
  );

  whp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .has_room (q_room),
    .pop      (pop),
    .has_data (q_data),
    .head     (head)
  );

  whp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .has_data  (q_data),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // samples never close a file, status results always do
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == (out_data.result_kind != KIND_SAMPLE)))
    else $error("last flag disagrees with result kind");

  // status results carry a zero sample
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind != KIND_SAMPLE) |-> out_data.sample == 16'sd0)
    else $error("status result with nonzero sample");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a command only pops while the queue holds one
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_data)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- tb/sv/whp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// whp_checker
// Watches the byte, result and register ports of the WAV header parser,
// predicts the results of every accepted byte and compares them in order.
// ----------------------------------------------------------------------------
module whp_checker import whp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire in_item_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire out_item_t   out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               mismatch_count,
  output int               pending,
  output int               results_seen
);

  typedef enum logic [2:0] {
    WALK_RIFF, WALK_CHUNK, WALK_FMT, WALK_SKIP, WALK_DATA, WALK_RAW, WALK_DONE
  } walk_t;

  cfg_t        cfg_shadow;
  walk_t       walk;
  logic [31:0] byte_idx;
  logic [31:0] tag_acc;
  logic [31:0] chunk_len;
  logic [31:0] remain;
  logic [15:0] fmt_code;
  logic [15:0] fmt_chans;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic        fmt_done;
  logic [7:0]  low_half;
  logic        have_low;

  out_item_t   due_results[$];

  initial begin
    mismatch_count = 0;
    pending        = 0;
    results_seen   = 0;
  end

  task automatic restart_walk();
    walk      = WALK_RIFF;
    byte_idx  = '0;
    tag_acc   = '0;
    chunk_len = '0;
    remain    = '0;
    fmt_code  = '0;
    fmt_chans = '0;
    fmt_rate  = '0;
    fmt_bits  = '0;
    fmt_done  = 1'b0;
    low_half  = '0;
    have_low  = 1'b0;
  endtask

  task automatic queue_result(input kind_t kind, input logic [15:0] smp, input logic fin);
    out_item_t r;
    r.result_kind = kind;
    r.sample      = smp;
    r.last        = fin;
    due_results.push_back(r);
  endtask

  // Pairs payload bytes into little-endian samples.
  task automatic pair_byte(input logic [7:0] b);
    if (have_low) begin
      have_low = 1'b0;
      queue_result(KIND_SAMPLE, {b, low_half}, 1'b0);
    end else begin
      low_half = b;
      have_low = 1'b1;
    end
  endtask

  task automatic parse_file_byte(input logic [7:0] b, input logic first, input logic fin);
    logic [32:0] skip_len;
    kind_t       end_kind;
    if (first) restart_walk();
    if (walk == WALK_RIFF && byte_idx == 0 && cfg_shadow.raw_pcm_mode) walk = WALK_RAW;

    case (walk)
      WALK_RIFF: begin
        tag_acc = {tag_acc[23:0], b};
        byte_idx++;
        if (byte_idx == 4 && tag_acc != TAG_RIFF) begin
          walk = WALK_DONE;
          queue_result(KIND_BADHDR, '0, 1'b1);
          return;
        end
        if (byte_idx == 12) begin
          if (tag_acc != TAG_WAVE) begin
            walk = WALK_DONE;
            queue_result(KIND_BADHDR, '0, 1'b1);
            return;
          end
          tag_acc  = '0;
          byte_idx = '0;
          walk     = WALK_CHUNK;
        end
      end
      WALK_CHUNK: begin
        if (byte_idx < 4) begin
          tag_acc = {tag_acc[23:0], b};
        end else begin
          if (byte_idx == 4) chunk_len = '0;
          chunk_len = chunk_len | ({24'd0, b} << {byte_idx[1:0], 3'b000});
        end
        byte_idx++;
        if (byte_idx == 8) begin
          byte_idx = '0;
          if (tag_acc == TAG_FMT) begin
            if (chunk_len < 16) begin
              walk = WALK_DONE;
              queue_result(KIND_UNSUP, '0, 1'b1);
              return;
            end
            remain = (chunk_len - 32'd16) + {31'd0, chunk_len[0]};
            walk   = WALK_FMT;
          end else if (tag_acc == TAG_DATA) begin
            if (!fmt_done || fmt_code != 16'd1 ||
                fmt_chans != cfg_shadow.expected_channels ||
                fmt_rate != cfg_shadow.expected_rate ||
                fmt_bits != cfg_shadow.expected_bits) begin
              walk = WALK_DONE;
              queue_result(KIND_UNSUP, '0, 1'b1);
              return;
            end
            remain   = {chunk_len[31:1], 1'b0};
            have_low = 1'b0;
            if (remain == 0) begin
              walk = WALK_DONE;
              queue_result(KIND_END, '0, 1'b1);
              return;
            end
            walk = WALK_DATA;
          end else begin
            // unknown chunk: skip payload plus pad, saturating
            skip_len = {1'b0, chunk_len} + {32'd0, chunk_len[0]};
            remain   = skip_len[32] ? 32'hFFFF_FFFF : skip_len[31:0];
            if (remain == 0) walk = WALK_CHUNK;
            else walk = WALK_SKIP;
          end
          tag_acc = '0;
        end
      end
      WALK_FMT: begin
        case (byte_idx)
          0:  fmt_code         = {8'd0, b};
          1:  fmt_code[15:8]   = b;
          2:  fmt_chans        = {8'd0, b};
          3:  fmt_chans[15:8]  = b;
          4:  fmt_rate         = {24'd0, b};
          5:  fmt_rate[15:8]   = b;
          6:  fmt_rate[23:16]  = b;
          7:  fmt_rate[31:24]  = b;
          14: fmt_bits         = {8'd0, b};
          15: fmt_bits[15:8]   = b;
          default: ;
        endcase
        byte_idx++;
        if (byte_idx == 16) begin
          fmt_done = 1'b1;
          byte_idx = '0;
          if (remain == 0) walk = WALK_CHUNK;
          else walk = WALK_SKIP;
        end
      end
      WALK_SKIP: begin
        remain--;
        if (remain == 0) begin
          byte_idx = '0;
          walk     = WALK_CHUNK;
        end
      end
      WALK_DATA: begin
        pair_byte(b);
        remain--;
        if (remain == 0) begin
          walk = WALK_DONE;
          queue_result(KIND_END, '0, 1'b1);
          return;
        end
      end
      WALK_RAW: pair_byte(b);
      default: return;
    endcase

    if (fin) begin
      if (walk == WALK_DATA || walk == WALK_RAW) end_kind = KIND_END;
      else if (walk == WALK_RIFF) end_kind = KIND_BADHDR;
      else end_kind = KIND_UNSUP;
      walk     = WALK_DONE;
      have_low = 1'b0;
      queue_result(end_kind, '0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cfg_shadow.raw_pcm_mode      = 1'b0;
      cfg_shadow.expected_rate     = RESET_RATE;
      cfg_shadow.expected_channels = RESET_CHANNELS;
      cfg_shadow.expected_bits     = RESET_BITS;
      restart_walk();
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAW_PCM_MODE:      cfg_shadow.raw_pcm_mode      = cfg_data[0];
          REG_EXPECTED_RATE:     cfg_shadow.expected_rate     = cfg_data;
          REG_EXPECTED_CHANNELS: cfg_shadow.expected_channels = cfg_data[15:0];
          REG_EXPECTED_BITS:     cfg_shadow.expected_bits     = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        parse_file_byte(in_data.file_byte, in_data.file_first, in_data.file_last);
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (due_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          $display("%0t: result with nothing expected: kind=%0d sample=%0d last=%0d",
                   $time, out_data.result_kind, out_data.sample, out_data.last);
        end else begin
          want = due_results.pop_front();
          if (out_data !== want) begin
            mismatch_count <= mismatch_count + 1;
            $display("%0t: mismatch: expected kind=%0d sample=%0d last=%0d,",
                     $time, want.result_kind, want.sample, want.last);
            $display("%0t:           got kind=%0d sample=%0d last=%0d",
                     $time, out_data.result_kind, out_data.sample, out_data.last);
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

// ----- tb/sv/wav_header_parser_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_header_parser_core_tb
// Feeds whole audio files, well-formed and broken, WAV and headerless, through
// the parser under several register settings with random stalls on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module wav_header_parser_core_tb import whp_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no accepted request
  localparam int DRAIN_CYCLES   = 12;    // queue depth plus output register, with margin
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int PHASE_BYTES    = 180;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_data;

  int mismatch_count;
  int pending;
  int results_seen;

  // Bytes of the file being built, plus run bookkeeping.
  logic [7:0]  file_bytes[$];
  int          files_sent     = 0;
  int          bytes_sent     = 0;
  int          settings_used  = 0;
  int          idle_cycles    = 0;

  // Register values in force, so that generated headers can match them.
  logic        cur_raw   = 1'b0;
  logic [31:0] cur_rate  = RESET_RATE;
  logic [15:0] cur_chans = RESET_CHANNELS;
  logic [15:0] cur_bits  = RESET_BITS;

  always #5 clk = ~clk;

  wav_header_parser_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  whp_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .results_seen   (results_seen)
  );

  // Idle stretch: mostly short, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // File assembly. Tags go out MSB first (the parser shifts them in from the
  // right); numeric fields are little endian.
  // ---------------------------------------------------------------------------
  task automatic put_tag(input logic [31:0] t);
    file_bytes.push_back(t[31:24]);
    file_bytes.push_back(t[23:16]);
    file_bytes.push_back(t[15:8]);
    file_bytes.push_back(t[7:0]);
  endtask

  task automatic put16le(input logic [15:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endtask

  task automatic put32le(input logic [31:0] v);
    put16le(v[15:0]);
    put16le(v[31:16]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_riff_header();
    put_tag(TAG_RIFF);
    put32le($urandom);
    put_tag(TAG_WAVE);
  endtask

  // Unknown chunk; odd lengths carry a pad byte.
  task automatic put_unknown_chunk();
    logic [31:0] t;
    int          len;
    t = $urandom;
    while (t == TAG_FMT || t == TAG_DATA) t = $urandom;
    len = $urandom_range(0, 9);
    put_tag(t);
    put32le(len);
    put_noise(len + (len % 2));
  endtask

  task automatic build_wav();
    logic [15:0] fcode;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    int          flen;
    int          dlen;
    int          declared;
    fcode = 16'd1;
    chans = cur_chans;
    rate  = cur_rate;
    bits  = cur_bits;
    // Now and then one fmt field disagrees with the registers.
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0: fcode = $urandom_range(0, 1) ? 16'd3 : 16'hFFFE;
        1: chans = chans ^ (16'd1 << $urandom_range(0, 15));
        2: rate  = rate ^ (32'd1 << $urandom_range(0, 31));
        default: bits = bits ^ (16'd1 << $urandom_range(0, 15));
      endcase
    end
    file_bytes.delete();
    put_riff_header();
    if ($urandom_range(0, 99) < 30) put_unknown_chunk();
    flen = 16 + (($urandom_range(0, 99) < 30) ? $urandom_range(1, 5) : 0);
    put_tag(TAG_FMT);
    put32le(flen);
    put16le(fcode);
    put16le(chans);
    put32le(rate);
    put32le($urandom);
    put16le(16'($urandom));
    put16le(bits);
    put_noise(flen - 16 + (flen % 2));
    if ($urandom_range(0, 99) < 20) put_unknown_chunk();
    dlen     = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 24);
    declared = dlen;
    // Declared size past the end of the file: ends early.
    if ($urandom_range(0, 99) < 15) declared = dlen + $urandom_range(1, 20);
    put_tag(TAG_DATA);
    put32le(declared);
    put_noise(dlen);
    // Bytes past the data chunk are ignored once it is used up.
    if ($urandom_range(0, 99) < 20) put_noise($urandom_range(1, 6));
  endtask

  task automatic build_random_file();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (cur_raw) begin
      if (pick < 80) begin
        file_bytes.delete();
        put_noise($urandom_range(1, 30));
      end else begin
        build_wav();
      end
    end else if (pick < 60) begin
      build_wav();
    end else if (pick < 68) begin
      // fmt chunk too short to hold the format fields
      file_bytes.delete();
      put_riff_header();
      len = $urandom_range(0, 15);
      put_tag(TAG_FMT);
      put32le(len);
      put_noise($urandom_range(0, 4));
    end else if (pick < 73) begin
      // data chunk with no fmt before it
      file_bytes.delete();
      put_riff_header();
      put_tag(TAG_DATA);
      put32le(4);
      put_noise(4);
    end else if (pick < 83) begin
      // one bit of the RIFF or WAVE magic flipped
      build_wav();
      len = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(8, 11);
      file_bytes[len] = file_bytes[len] ^ (8'd1 << $urandom_range(0, 7));
    end else if (pick < 90) begin
      file_bytes.delete();
      put_noise($urandom_range(1, 20));
    end else begin
      // unknown chunk with a length that saturates or nearly so
      file_bytes.delete();
      put_riff_header();
      put_tag($urandom_range(0, 1) ? 32'h4C49_5354 : 32'h6A75_6E6B);
      case ($urandom_range(0, 2))
        0: put32le(32'hFFFF_FFFF);
        1: put32le(32'hFFFF_FFFE);
        default: put32le($urandom);
      endcase
      put_noise($urandom_range(3, 10));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side. in_valid is only lowered when a gap follows, so a back to
  // back request never sees two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic first, input logic fin,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{file_byte: b, file_first: first, file_last: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file(input int count, input bit with_last, input bit steady);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = (steady || $urandom_range(0, 99) < 60) ? 0 : pause_len();
      send_byte(file_bytes[i], i == 0, with_last && (i == count - 1), gap);
    end
    files_sent++;
  endtask

  // Block idle: nothing offered, every result out, then the pipeline tail.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // All four registers, back to back; unused upper bits carry noise.
  task automatic apply_setting(input logic raw, input logic [31:0] rate,
                               input logic [15:0] chans, input logic [15:0] bits);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= REG_RAW_PCM_MODE;
    cfg_data  <= {junk[31:1], raw};
    @(posedge clk);
    cfg_index <= REG_EXPECTED_RATE;
    cfg_data  <= rate;
    @(posedge clk);
    cfg_index <= REG_EXPECTED_CHANNELS;
    cfg_data  <= {junk[15:0], chans};
    @(posedge clk);
    cfg_index <= REG_EXPECTED_BITS;
    cfg_data  <= {junk[31:16], bits};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_raw   = raw;
    cur_rate  = rate;
    cur_chans = chans;
    cur_bits  = bits;
  endtask

  task automatic run_phase(input bit write_cfg, input logic raw, input logic [31:0] rate,
                           input logic [15:0] chans, input logic [15:0] bits);
    int  stop_at;
    int  count;
    bit  with_last;
    if (write_cfg) begin
      drain_block();
      apply_setting(raw, rate, chans, bits);
    end
    settings_used++;
    stop_at = bytes_sent + PHASE_BYTES;
    while (bytes_sent < stop_at) begin
      build_random_file();
      count     = file_bytes.size();
      with_last = $urandom_range(0, 99) < 90;
      // Cut short somewhere, header included.
      if ($urandom_range(0, 99) < 12) count = $urandom_range(1, count);
      send_file(count, with_last, $urandom_range(0, 99) < 20);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset register values.
    // Wrong RIFF magic, answered at the fourth byte; the next byte is ignored.
    file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58, 8'hFF};
    send_file(5, 1'b1, 1'b1);
    // File ending inside the 12-byte header.
    file_bytes = '{8'h52, 8'h49};
    send_file(2, 1'b1, 1'b0);
    // Good RIFF, wrong WAVE magic, with extreme size bytes.
    file_bytes = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'hFF, 8'h00, 8'hFF,
                   8'h57, 8'h41, 8'h56, 8'h46};
    send_file(12, 1'b1, 1'b0);

    run_phase(1'b0, 1'b0, RESET_RATE, RESET_CHANNELS, RESET_BITS);
    run_phase(1'b1, 1'b0, 32'd44100, 16'd2, 16'd16);
    run_phase(1'b1, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    run_phase(1'b1, 1'b1, $urandom, 16'($urandom), 16'($urandom));
    run_phase(1'b1, 1'b0, 32'd0, 16'd0, 16'd0);
    run_phase(1'b1, 1'b0, $urandom, 16'($urandom), 16'($urandom));
    run_phase(1'b1, 1'b1, RESET_RATE, RESET_CHANNELS, RESET_BITS);
    run_phase(1'b1, 1'b0, RESET_RATE, RESET_CHANNELS, RESET_BITS);

    drain_block();
    $display("Covered %0d files, %0d bytes over %0d register settings (WAV and raw PCM).",
             files_sent, bytes_sent, settings_used);
    $display("Compared %0d results, with receiver hold-offs filling the block.",
             results_seen);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, ready stretches, and two long hold-offs while
  // the sender keeps offering, so the command queue fills and in_ready drops.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int steady_left;
    int holds_done;
    int pick;
    stall_left  = 0;
    steady_left = 0;
    holds_done  = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= ((holds_done == 0) ? 40 : 400)) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
        @(posedge clk);
      end else if (steady_left > 0) begin
        out_ready <= 1'b1;
        steady_left--;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) steady_left = $urandom_range(50, 150);
        else if (pick < 35) stall_left = pause_len();
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: any accepted request on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
